[hdl/psl_pkg.sv]
// shared types and constants for the per-source connection limiter
package psl_pkg;

   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 16;
   localparam int TOTAL_W = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam logic [COUNT_W-1:0] MAX_PER_SOURCE_RESET = 16'd4;
   localparam logic [TOTAL_W-1:0] MAX_TOTAL_RESET      = 20'd64;

   typedef enum logic [1:0] {
      ACT_CHECK = 2'd0,
      ACT_OPEN  = 2'd1,
      ACT_CLOSE = 2'd2,
      ACT_CLEAR = 2'd3
   } psl_action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_PER_SOURCE = 2'd0,
      CSR_MAX_TOTAL      = 2'd1
   } psl_csr_idx_type;

   // limits held by the register block
   typedef struct packed {
      logic [COUNT_W-1:0] max_per_source;
      logic [TOTAL_W-1:0] max_total;
   } psl_cfg_type;

   // operation presented to the table
   typedef struct packed {
      logic                fire;
      psl_action_type      action;
      logic [ADDR_W-1:0]   addr;
   } psl_op_type;

   // table outcome for the operation
   typedef struct packed {
      logic [COUNT_W-1:0] source_count;
      logic               table_full;
      logic               total_inc;
      logic               total_dec;
   } psl_res_type;

endpackage

[hdl/psl_if.sv]
// valid/ready channel interfaces for requests, responses and register writes
interface psl_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  action;
   logic [psl_pkg::ADDR_W-1:0]  source_addr;

   modport source (output valid, output action, output source_addr, input ready);
   modport sink   (input valid, input action, input source_addr, output ready);
endinterface

interface psl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         allowed;
   logic [psl_pkg::COUNT_W-1:0]  source_count;
   logic [psl_pkg::TOTAL_W-1:0]  total_count;
   logic                         table_full;

   modport source (output valid, output allowed, output source_count,
                   output total_count, output table_full, input ready);
   modport sink   (input valid, input allowed, input source_count,
                   input total_count, input table_full, output ready);
endinterface

interface psl_csr_if;
   logic                            valid;
   logic                            ready;
   logic [psl_pkg::CSR_IDX_W-1:0]   index;
   logic [psl_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/per_source_connection_limiter.sv]
// per-source connection limiter: input stage, table pass and result register
// flow: a request beat goes into the input stage, then its outcome into the result register
// throughput: one beat per cycle unless responses stall; the single lookup and update pass
//   over the table and the running-total counter sit between input stage and result register
// reset: all table entries invalid, running total zero, limits back to 4 per source and 64 total
// no clearing pass: the table valid bits reset at once
module per_source_connection_limiter #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic      clock,
   input  logic      reset,
   psl_req_if.sink   req_bus,
   psl_rsp_if.source rsp_bus,
   psl_csr_if.sink   csr_bus
);

   psl_pkg::psl_cfg_type cfg;
   psl_pkg::psl_op_type  op;
   psl_pkg::psl_res_type res;

   // input stage
   logic                         stage_valid_ff, stage_valid_in;
   psl_pkg::psl_action_type      stage_action_ff;
   logic [psl_pkg::ADDR_W-1:0]   stage_addr_ff;

   // running total of open connections
   logic [psl_pkg::TOTAL_W-1:0]  total_ff, total_in;

   // result register
   logic                         out_valid_ff, out_valid_in;
   logic                         out_allowed_ff, out_allowed_in;
   logic [psl_pkg::COUNT_W-1:0]  out_count_ff, out_count_in;
   logic [psl_pkg::TOTAL_W-1:0]  out_total_ff, out_total_in;
   logic                         out_full_ff, out_full_in;

   logic req_beat, advance;

   psl_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   psl_cam #(
      .ENTRIES (TABLE_ENTRIES)
   ) u_cam (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .res   (res)
   );

   // stage moves on when the result register is empty or being drained
   assign advance         = stage_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready   = !stage_valid_ff || advance;
   assign req_beat        = req_bus.valid && req_bus.ready;
   assign stage_valid_in  = req_beat || (stage_valid_ff && !advance);

   assign op.fire   = advance;
   assign op.action = stage_action_ff;
   assign op.addr   = stage_addr_ff;

   // running total: zero on clear, saturate high on open, hold at zero on close
   always_comb begin
      total_in = total_ff;
      if (stage_action_ff == psl_pkg::ACT_CLEAR) begin
         total_in = '0;
      end else if (res.total_inc && (total_ff != psl_pkg::TOTAL_MAX)) begin
         total_in = total_ff + psl_pkg::TOTAL_W'(1);
      end else if (res.total_dec && (total_ff != '0)) begin
         total_in = total_ff - psl_pkg::TOTAL_W'(1);
      end
   end

   // result beat built from the table outcome; allowed uses the pre-action total, the reported total is post-action
   always_comb begin
      out_valid_in   = advance || (out_valid_ff && !rsp_bus.ready);
      out_allowed_in = (stage_action_ff == psl_pkg::ACT_CHECK) &&
                       (total_ff < cfg.max_total) &&
                       (res.source_count < cfg.max_per_source);
      out_count_in   = res.source_count;
      out_total_in   = total_in;
      out_full_in    = res.table_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         total_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         if (advance) total_ff <= total_in;
      end
   end

   // staged action starts as a harmless check so the table decode never sees an unknown code
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_action_ff <= psl_pkg::ACT_CHECK;
      end else if (req_beat) begin
         stage_action_ff <= psl_pkg::psl_action_type'(req_bus.action);
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         stage_addr_ff   <= req_bus.source_addr;
      end
      if (advance) begin
         out_allowed_ff <= out_allowed_in;
         out_count_ff   <= out_count_in;
         out_total_ff   <= out_total_in;
         out_full_ff    <= out_full_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.allowed      = out_allowed_ff;
   assign rsp_bus.source_count = out_count_ff;
   assign rsp_bus.total_count  = out_total_ff;
   assign rsp_bus.table_full   = out_full_ff;

   // a clear leaves the total at zero
   a_clear_zeroes_total: assert property (@(posedge clock) disable iff (reset)
      advance && (stage_action_ff == psl_pkg::ACT_CLEAR) |=> total_ff == '0)
      else $error("total not zero after clear");

   // table full is only reported for an open
   a_full_only_on_open: assert property (@(posedge clock) disable iff (reset)
      advance && (stage_action_ff != psl_pkg::ACT_OPEN) |=> !out_full_ff)
      else $error("table full flagged for a non-open action");

   // an admitted source is under its limit
   a_allowed_under_limit: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_allowed_ff |-> out_count_ff < cfg.max_per_source)
      else $error("admitted source at or over its limit");

   // a stalled response keeps the staged request waiting
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && out_valid_ff && !rsp_bus.ready |=> stage_valid_ff)
      else $error("staged request lost under backpressure");

   // the total only changes on a processed beat
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      !advance |=> total_ff == $past(total_ff))
      else $error("total changed without a processed beat");

endmodule

[hdl/psl_csr.sv]
// limit registers written through the csr channel
module psl_csr (
   input  logic                 clock,
   input  logic                 reset,
   psl_csr_if.sink              csr,
   output psl_pkg::psl_cfg_type cfg
);

   psl_pkg::psl_cfg_type cfg_ff, cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (psl_pkg::psl_csr_idx_type'(csr.index))
            psl_pkg::CSR_MAX_PER_SOURCE: begin
               cfg_in.max_per_source = csr.data[psl_pkg::COUNT_W-1:0];
            end
            psl_pkg::CSR_MAX_TOTAL: begin
               cfg_in.max_total = csr.data[psl_pkg::TOTAL_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_per_source <= psl_pkg::MAX_PER_SOURCE_RESET;
         cfg_ff.max_total      <= psl_pkg::MAX_TOTAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/psl_cam.sv]
// associative table of source addresses and open counts with lookup and update
module psl_cam #(
   parameter int ENTRIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  psl_pkg::psl_op_type  op,
   output psl_pkg::psl_res_type res
);

   logic [ENTRIES-1:0]          valid_ff, valid_in;
   logic [psl_pkg::ADDR_W-1:0]  addr_ff  [ENTRIES];
   logic [psl_pkg::ADDR_W-1:0]  addr_in  [ENTRIES];
   logic [psl_pkg::COUNT_W-1:0] count_ff [ENTRIES];
   logic [psl_pkg::COUNT_W-1:0] count_in [ENTRIES];

   logic [ENTRIES-1:0]          hit_vec, hit_first, free_first;
   logic                        hit_any, free_any;
   logic [psl_pkg::COUNT_W-1:0] hit_count;

   // parallel compare, then lowest matching and lowest free entry
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (addr_ff[i] == op.addr);
      end
      hit_first  = hit_vec & (~hit_vec + ENTRIES'(1));
      free_first = ~valid_ff & (valid_ff + ENTRIES'(1));
      hit_any    = |hit_vec;
      free_any   = |free_first;
      hit_count  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_count = hit_count | ({psl_pkg::COUNT_W{hit_first[i]}} & count_ff[i]);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      addr_in  = addr_ff;
      count_in = count_ff;
      res      = '0;
      unique case (op.action)
         psl_pkg::ACT_CHECK: begin
            res.source_count = hit_count;
         end
         psl_pkg::ACT_OPEN: begin
            if (hit_any) begin
               if (hit_count != psl_pkg::COUNT_MAX) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (hit_first[i]) count_in[i] = hit_count + psl_pkg::COUNT_W'(1);
                  end
                  res.total_inc    = 1'b1;
                  res.source_count = hit_count + psl_pkg::COUNT_W'(1);
               end else begin
                  res.source_count = hit_count;
               end
            end else if (free_any) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (free_first[i]) begin
                     valid_in[i] = 1'b1;
                     addr_in[i]  = op.addr;
                     count_in[i] = psl_pkg::COUNT_W'(1);
                  end
               end
               res.total_inc    = 1'b1;
               res.source_count = psl_pkg::COUNT_W'(1);
            end else begin
               res.table_full = 1'b1;
            end
         end
         psl_pkg::ACT_CLOSE: begin
            if (hit_any) begin
               res.total_dec = 1'b1;
               if (hit_count > psl_pkg::COUNT_W'(1)) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (hit_first[i]) count_in[i] = hit_count - psl_pkg::COUNT_W'(1);
                  end
                  res.source_count = hit_count - psl_pkg::COUNT_W'(1);
               end else begin
                  valid_in = valid_ff & ~hit_first;
               end
            end
         end
         psl_pkg::ACT_CLEAR: begin
            valid_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (op.fire) begin
         valid_ff <= valid_in;
      end
   end

   // entry payload is only read while its valid bit is set
   always_ff @(posedge clock) begin
      if (op.fire) begin
         addr_ff  <= addr_in;
         count_ff <= count_in;
      end
   end

endmodule

[test/tb.sv]
// testbench for the per-source connection limiter: directed and random traffic against a predictor
module tb;

   localparam int TABLE_ENTRIES   = 16;
   localparam int RSP_HOLD_CYCLES = 300;
   // register index with no register behind it, written once to show it is ignored
   localparam logic [psl_pkg::CSR_IDX_W-1:0] CSR_SPARE_IDX = 2'd3;

   // predictor of the limiter: its own copy of the source table, running total and limits,
   // plus the queue of responses it still expects
   class admission_tracker;
      typedef struct packed {
         logic                        allowed;
         logic [psl_pkg::COUNT_W-1:0] source_count;
         logic [psl_pkg::TOTAL_W-1:0] total_count;
         logic                        table_full;
      } outcome_type;

      bit                          slot_used  [TABLE_ENTRIES];
      bit [psl_pkg::ADDR_W-1:0]    slot_addr  [TABLE_ENTRIES];
      bit [psl_pkg::COUNT_W-1:0]   slot_count [TABLE_ENTRIES];
      bit [psl_pkg::TOTAL_W-1:0]   open_total;
      bit [psl_pkg::COUNT_W-1:0]   per_source_limit;
      bit [psl_pkg::TOTAL_W-1:0]   total_limit;
      outcome_type                 expected_outcomes[$];
      int                          mismatches;

      function new();
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         open_total       = '0;
         per_source_limit = psl_pkg::MAX_PER_SOURCE_RESET;
         total_limit      = psl_pkg::MAX_TOTAL_RESET;
         mismatches       = 0;
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction

      function void set_limit(logic [psl_pkg::CSR_IDX_W-1:0] index,
                              logic [psl_pkg::CSR_DATA_W-1:0] data);
         case (index)
            psl_pkg::CSR_MAX_PER_SOURCE: per_source_limit = data[psl_pkg::COUNT_W-1:0];
            psl_pkg::CSR_MAX_TOTAL:      total_limit      = data[psl_pkg::TOTAL_W-1:0];
            default: ;
         endcase
      endfunction

      // lowest valid slot holding the address, or -1
      function int lookup(logic [psl_pkg::ADDR_W-1:0] addr);
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_used[i] && slot_addr[i] == addr) return i;
         return -1;
      endfunction

      function void note_request(psl_pkg::psl_action_type act,
                                 logic [psl_pkg::ADDR_W-1:0] addr);
         outcome_type o;
         int          hit;
         int          free_slot;
         o   = '0;
         hit = lookup(addr);
         case (act)
            psl_pkg::ACT_CHECK: begin
               // a check never allocates: an absent source counts as zero
               o.source_count = (hit >= 0) ? slot_count[hit] : '0;
               o.allowed = (open_total < total_limit) && (o.source_count < per_source_limit);
            end
            psl_pkg::ACT_OPEN: begin
               if (hit < 0) begin
                  free_slot = -1;
                  for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                     if (!slot_used[i]) free_slot = i;
                  if (free_slot < 0) begin
                     o.table_full = 1'b1;
                  end else begin
                     slot_used[free_slot]  = 1'b1;
                     slot_addr[free_slot]  = addr;
                     slot_count[free_slot] = psl_pkg::COUNT_W'(1);
                     if (open_total < psl_pkg::TOTAL_MAX) open_total++;
                     o.source_count = psl_pkg::COUNT_W'(1);
                  end
               end else begin
                  // saturated count leaves the total alone too
                  if (slot_count[hit] < psl_pkg::COUNT_MAX) begin
                     slot_count[hit]++;
                     if (open_total < psl_pkg::TOTAL_MAX) open_total++;
                  end
                  o.source_count = slot_count[hit];
               end
            end
            psl_pkg::ACT_CLOSE: begin
               if (hit >= 0) begin
                  if (slot_count[hit] > 1) begin
                     slot_count[hit]--;
                     o.source_count = slot_count[hit];
                  end else begin
                     slot_used[hit]  = 1'b0;
                     slot_count[hit] = '0;
                  end
                  if (open_total > 0) open_total--;
               end
            end
            default: begin
               foreach (slot_used[i]) slot_used[i] = 1'b0;
               open_total = '0;
            end
         endcase
         o.total_count = open_total;
         expected_outcomes.push_back(o);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want)
            report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
      endtask

      task check_response(logic allowed, logic [psl_pkg::COUNT_W-1:0] source_count,
                          logic [psl_pkg::TOTAL_W-1:0] total_count, logic table_full);
         outcome_type o;
         if (expected_outcomes.size() == 0) begin
            report_mismatch("response beat with nothing expected");
            return;
         end
         o = expected_outcomes.pop_front();
         compare_field("allowed", 32'(o.allowed), 32'(allowed));
         compare_field("source_count", 32'(o.source_count), 32'(source_count));
         compare_field("total_count", 32'(o.total_count), 32'(total_count));
         compare_field("table_full", 32'(o.table_full), 32'(table_full));
      endtask
   endclass

   logic clock;
   logic reset;

   psl_req_if req_if ();
   psl_rsp_if rsp_if ();
   psl_csr_if csr_if ();

   admission_tracker sb;

   // per-phase idling switches, and a one-shot request for a long response hold-off
   bit req_idle_en;
   bit rsp_idle_en;
   bit rsp_hold_pending;

   per_source_connection_limiter #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // run limit, far above the slowest legal run
   initial begin
      #1000000;
      $display("simulation failed");
      $finish;
   end

   // monitors sample at the edge, before any driver update lands
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         sb.note_request(psl_pkg::psl_action_type'(req_if.action), req_if.source_addr);
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_response(rsp_if.allowed, rsp_if.source_count, rsp_if.total_count,
                           rsp_if.table_full);
      if (!reset && csr_if.valid && csr_if.ready)
         sb.set_limit(csr_if.index, csr_if.data);
   end

   // response side: a random stall before each beat, or one long hold-off on request
   initial begin : rsp_sink
      int stall;
      rsp_if.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_hold_pending) begin
            stall = RSP_HOLD_CYCLES;
            rsp_hold_pending = 1'b0;
         end else begin
            stall = rsp_idle_en ? $urandom_range(0, 10) : 0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // one request beat, after a random gap; valid stays up when the gap is zero
   task automatic send_req(psl_pkg::psl_action_type act, logic [psl_pkg::ADDR_W-1:0] addr);
      int gap;
      gap = req_idle_en ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.action      <= act;
      req_if.source_addr <= addr;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // stop offering and wait until every expected response has come back
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_beat(logic [psl_pkg::CSR_IDX_W-1:0] index,
                           logic [psl_pkg::CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   // both limits, back to back, then the spare index if asked; the unused upper data bits carry noise
   task automatic program_limits(logic [psl_pkg::COUNT_W-1:0] per_src,
                                 logic [psl_pkg::TOTAL_W-1:0] total, bit poke_spare);
      csr_beat(psl_pkg::CSR_MAX_PER_SOURCE, {16'($urandom_range(0, 65535)), per_src});
      csr_beat(psl_pkg::CSR_MAX_TOTAL, {12'($urandom_range(0, 4095)), total});
      if (poke_spare) csr_beat(CSR_SPARE_IDX, $urandom);
      csr_if.valid <= 1'b0;
   endtask

   // mostly open/close/check on a small pool of sources so the table fills and drains,
   // with a few stray addresses and the odd clear mixed in
   task automatic run_traffic(int n_items, bit hold);
      logic [psl_pkg::ADDR_W-1:0] pool [24];
      int                         pool_size;
      int                         sel;
      psl_pkg::psl_action_type    act;
      logic [psl_pkg::ADDR_W-1:0] addr;
      if (hold) begin
         req_idle_en      = 1'b0;
         rsp_hold_pending = 1'b1;
      end else begin
         req_idle_en = $urandom_range(0, 2) != 0;
         rsp_idle_en = $urandom_range(0, 2) != 0;
      end
      pool_size = $urandom_range(2, 24);
      for (int i = 0; i < pool_size; i++) pool[i] = $urandom;
      repeat (n_items) begin
         sel  = $urandom_range(0, 99);
         addr = pool[$urandom_range(0, pool_size - 1)];
         if (sel < 40)      act = psl_pkg::ACT_OPEN;
         else if (sel < 65) act = psl_pkg::ACT_CLOSE;
         else if (sel < 97) act = psl_pkg::ACT_CHECK;
         else               act = psl_pkg::ACT_CLEAR;
         if ($urandom_range(0, 99) < 6) addr = $urandom;
         send_req(act, addr);
      end
   endtask

   initial begin : stimulus
      sb = new();
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.action      = psl_pkg::ACT_CHECK;
      req_if.source_addr = '0;
      csr_if.valid       = 1'b0;
      csr_if.index       = psl_pkg::CSR_MAX_PER_SOURCE;
      csr_if.data        = '0;
      req_idle_en        = 1'b1;
      rsp_idle_en        = 1'b1;
      rsp_hold_pending   = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset limits
      send_req(psl_pkg::ACT_CHECK, 32'h0000_0000);  // absent source: count zero, no allocation
      send_req(psl_pkg::ACT_OPEN, 32'h0000_0000);
      send_req(psl_pkg::ACT_OPEN, 32'hFFFF_FFFF);
      send_req(psl_pkg::ACT_OPEN, 32'hFFFF_FFFF);
      send_req(psl_pkg::ACT_CLOSE, 32'h1234_5678);  // close on an absent source is ignored
      send_req(psl_pkg::ACT_CLOSE, 32'hFFFF_FFFF);  // two down to one
      send_req(psl_pkg::ACT_CLOSE, 32'hFFFF_FFFF);  // count one frees the entry
      send_req(psl_pkg::ACT_CHECK, 32'hFFFF_FFFF);
      // fill every free entry, then one more source finds the table full
      for (int i = 1; i < TABLE_ENTRIES; i++)
         send_req(psl_pkg::ACT_OPEN, 32'hA5A5_0000 + i);
      send_req(psl_pkg::ACT_OPEN, 32'h5A5A_5A5A);
      send_req(psl_pkg::ACT_CHECK, 32'h5A5A_5A5A);
      send_req(psl_pkg::ACT_CLEAR, 32'hFFFF_FFFF);
      drain();

      // random phases under several limit settings, extremes first
      program_limits('0, '0, 1'b1);
      run_traffic(100, 1'b0);
      drain();
      program_limits(16'd1, 20'd1, 1'b0);
      run_traffic(100, 1'b0);
      drain();
      // response side held off long enough for the block to back up into its input
      program_limits(16'd2, 20'd8, 1'b0);
      run_traffic(100, 1'b1);
      drain();
      program_limits(psl_pkg::COUNT_MAX, psl_pkg::TOTAL_MAX, 1'b0);
      run_traffic(100, 1'b0);
      drain();
      repeat (3) begin
         program_limits(16'($urandom_range(0, 6)), 20'($urandom_range(0, 40)), 1'b0);
         run_traffic(100, 1'b0);
         drain();
      end
      program_limits(psl_pkg::MAX_PER_SOURCE_RESET, psl_pkg::MAX_TOTAL_RESET, 1'b0);
      run_traffic(100, 1'b0);
      drain();

      // let any stray beat show up before the verdict
      repeat (6) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
